/* rtl/rcr_pkg.sv */
// shared types, constants and the sine table builder for the raycast column renderer
`timescale 1ns / 1ps
package rcr_pkg;

  // sizing
  localparam int MAP_CELLS     = 4096;
  localparam int MAP_AW        = $clog2(MAP_CELLS);
  localparam int SCREEN_HEIGHT = 64;
  localparam int TRIG_ENTRIES  = 4096;
  localparam int ANGLE_W       = 12;
  localparam int TRIG_SHIFT    = ANGLE_W - $clog2(TRIG_ENTRIES);
  localparam int QUARTER       = 1024;
  localparam int SIN_W         = 16;
  localparam int DIV_NUM_W     = 21;
  localparam int DIV_DEN_W     = 16;
  localparam int DIST_W        = 15;
  localparam int POS_W         = 32;
  localparam int INC_W         = 25;
  localparam int CEIL_W        = 17;
  localparam int CFG_W         = 14;

  // pixel colors
  localparam logic [31:0] COL_CEIL  = 32'hFFFF0000;
  localparam logic [31:0] COL_WALL  = 32'hFF0000FF;
  localparam logic [31:0] COL_FLOOR = 32'hFF00FF00;

  // sine table constants, Q28
  localparam logic [63:0] Q28_ONE          = 64'd268435456;
  localparam logic [63:0] RAD_PER_UNIT_Q28 = 64'd411775;

  // configuration register indexes
  localparam logic [2:0] CFG_FOV          = 3'd0;
  localparam logic [2:0] CFG_MAX_DISTANCE = 3'd1;
  localparam logic [2:0] CFG_STEP_SIZE    = 3'd2;
  localparam logic [2:0] CFG_MAP_WIDTH    = 3'd3;
  localparam logic [2:0] CFG_MAP_HEIGHT   = 3'd4;
  localparam logic [2:0] CFG_SCREEN_WIDTH = 3'd5;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_RENDER = 1'b1;

  typedef struct packed {
    logic        action;
    logic [11:0] cell_index;
    logic        cell_is_wall;
    logic [9:0]  column;
    logic [13:0] player_x;
    logic [13:0] player_y;
    logic [11:0] player_angle;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  out_column;
    logic [5:0]  row;
    logic [31:0] pixel_color;
    logic [13:0] wall_distance;
    logic        last_of_column;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ANG_START,
    ST_ANG_WAIT,
    ST_SIN_X,
    ST_SIN_Y,
    ST_TRIG_Y,
    ST_M_ADV,
    ST_M_ADDR,
    ST_M_TEST,
    ST_ROW_START,
    ST_ROW_WAIT,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clr_step;
    logic map_write;
    logic load_item;
    logic div_start;
    logic div_row;
    logic ang_latch;
    logic trig_y;
    logic cap_sx;
    logic march_init;
    logic march_adv;
    logic march_addr;
    logic march_test;
    logic row_latch;
    logic emit_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic div_done;
    logic march_go;
    logic march_done;
    logic out_free;
    logic last_row;
  } dp_status_t;

  typedef logic [SIN_W-2:0] sin_tab_t [0:QUARTER];

  // quarter wave sine, degree 9 series in Q28, rounded to Q14
  function automatic sin_tab_t sin_table();
    sin_tab_t    tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    for (int a = 0; a <= QUARTER; a++) begin
      x  = 64'(a) * RAD_PER_UNIT_Q28;
      x2 = (x * x) >> 28;
      t  = Q28_ONE - x2 / 72;
      t  = Q28_ONE - ((x2 * t) >> 28) / 42;
      t  = Q28_ONE - ((x2 * t) >> 28) / 20;
      t  = Q28_ONE - ((x2 * t) >> 28) / 6;
      s  = (x * t) >> 28;
      r  = (s + 64'd8192) >> 14;
      if (r > 64'd16384) begin
        r = 64'd16384;
      end
      tab[a] = r[SIN_W-2:0];
    end
    return tab;
  endfunction

endpackage

/* rtl/rcr_div.sv */
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module rcr_div import rcr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  // trial subtract of the next dividend bit
  always_comb begin
    trial = {rem, quo[DIV_NUM_W-1]};
    fits  = trial >= {1'b0, den_q};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_NUM_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_q <= den;
    end else if (busy) begin
      rem <= fits ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
      quo <= {quo[DIV_NUM_W-2:0], fits};
    end
  end

endmodule

/* rtl/rcr_sin_rom.sv */
// sine lookup with quadrant folding, registered read
`timescale 1ns / 1ps
module rcr_sin_rom import rcr_pkg::*; (
  input  logic                     clk,
  input  logic [ANGLE_W-1:0]       phase,
  output logic signed [SIN_W-1:0]  sin_q
);

  localparam sin_tab_t SIN_TAB = sin_table();

  logic [1:0]       quad;
  logic [9:0]       frac;
  logic [10:0]      idx;
  logic [SIN_W-1:0] mag;

  // fold onto the quarter wave
  always_comb begin
    quad = phase[ANGLE_W-1:ANGLE_W-2];
    frac = phase[9:0];
    idx  = quad[0] ? 11'(QUARTER) - {1'b0, frac} : {1'b0, frac};
    mag  = {1'b0, SIN_TAB[idx]};
  end

  always_ff @(posedge clk) begin
    sin_q <= quad[1] ? $signed(-mag) : $signed(mag);
  end

endmodule

/* rtl/rcr_datapath.sv */
// datapath: config registers, wall map, angle, trig, march, row bounds and output register
`timescale 1ns / 1ps
module rcr_datapath import rcr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  in_item_t         in_data,
  input  dp_cmd_t          cmd,
  output dp_status_t       st,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  // configuration
  logic [10:0] fov;
  logic [13:0] maxd;
  logic [7:0]  step;
  logic [6:0]  mw;
  logic [6:0]  mh;
  logic [10:0] sw;

  // item and work registers
  logic [9:0]               column;
  logic [13:0]              px;
  logic [13:0]              py;
  logic [11:0]              pa;
  logic [ANGLE_W-1:0]       ray;
  logic signed [INC_W-1:0]  inc_x;
  logic signed [INC_W-1:0]  inc_y;
  logic signed [POS_W-1:0]  posx;
  logic signed [POS_W-1:0]  posy;
  logic [DIST_W-1:0]        d;
  logic                     outside;
  logic                     addr_ok;
  logic                     map_q;
  logic signed [CEIL_W-1:0] ceil_row;
  logic [5:0]               row_cnt;
  logic [MAP_AW-1:0]        clr_addr;

  // wall map
  logic wall_map [MAP_CELLS];

  // combinational helpers
  logic [7:0]               step_eff;
  logic [10:0]              sw_eff;
  logic [ANGLE_W-1:0]       q_ang;
  logic [ANGLE_W-1:0]       phase;
  logic signed [SIN_W-1:0]  sin_q;
  logic [DIV_NUM_W-1:0]     div_num;
  logic [DIV_DEN_W-1:0]     div_den;
  logic                     div_done;
  logic [DIV_NUM_W-1:0]     quo;
  logic                     d_small;
  logic [DIST_W-1:0]        mag;
  logic [9:0]               cx;
  logic [9:0]               cy;
  logic                     out_now;
  logic [14:0]              addr;
  logic                     we;
  logic [MAP_AW-1:0]        waddr;
  logic                     wdata;
  logic signed [CEIL_W-1:0] floor_row;
  logic signed [CEIL_W-1:0] ysig;
  logic [31:0]              color;
  logic [CEIL_W-1:0]        q_row;

  always_comb begin
    step_eff = (step == '0) ? 8'd1 : step;
    sw_eff   = (sw == '0) ? 11'd1 : sw;
    q_ang    = (ray >> TRIG_SHIFT) << TRIG_SHIFT;
    phase    = cmd.trig_y ? q_ang + ANGLE_W'(QUARTER) : q_ang;
  end

  // divider operands: ray spread or row bound
  always_comb begin
    d_small = d < DIST_W'(512);
    mag     = d_small ? DIST_W'(512) - d : d - DIST_W'(512);
    if (cmd.div_row) begin
      div_num = DIV_NUM_W'(mag * SCREEN_HEIGHT);
      div_den = {d, 1'b0};
    end else begin
      div_num = {11'b0, column} * {10'b0, fov};
      div_den = {5'b0, sw_eff};
    end
  end

  rcr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  rcr_sin_rom u_sin (
    .clk   (clk),
    .phase (phase),
    .sin_q (sin_q)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fov  <= 11'd683;
      maxd <= 14'd4096;
      step <= 8'd26;
      mw   <= 7'd16;
      mh   <= 7'd16;
      sw   <= 11'd120;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FOV:          fov  <= cfg_data[10:0];
        CFG_MAX_DISTANCE: maxd <= cfg_data[13:0];
        CFG_STEP_SIZE:    step <= cfg_data[7:0];
        CFG_MAP_WIDTH:    mw   <= cfg_data[6:0];
        CFG_MAP_HEIGHT:   mh   <= cfg_data[6:0];
        CFG_SCREEN_WIDTH: sw   <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // map cell lookup from current position
  always_comb begin
    cx      = {1'b0, posx[POS_W-2:22]};
    cy      = {1'b0, posy[POS_W-2:22]};
    out_now = posx[POS_W-1] || posy[POS_W-1] || (cx >= {3'b0, mw}) || (cy >= {3'b0, mh});
    addr    = 15'(cy[6:0] * mw) + {8'b0, cx[6:0]};
  end

  // map write port: clearing pass or cell write
  always_comb begin
    we    = 1'b0;
    waddr = in_data.cell_index[MAP_AW-1:0];
    wdata = in_data.cell_is_wall;
    if (cmd.clr_step) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = 1'b0;
    end else if (cmd.map_write) begin
      we = {1'b0, in_data.cell_index} < 13'(MAP_CELLS);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      wall_map[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.march_addr) begin
      map_q <= wall_map[addr[MAP_AW-1:0]];
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // item, angle, trig and march registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      column <= in_data.column;
      px     <= in_data.player_x;
      py     <= in_data.player_y;
      pa     <= in_data.player_angle;
    end
    if (cmd.ang_latch) begin
      ray <= pa - {2'b0, fov[10:1]} + quo[ANGLE_W-1:0];
    end
    if (cmd.cap_sx) begin
      inc_x <= sin_q * $signed({1'b0, step_eff});
    end
    if (cmd.march_init) begin
      inc_y <= sin_q * $signed({1'b0, step_eff});
      d     <= '0;
      posx  <= $signed({4'b0, px, 14'b0});
      posy  <= $signed({4'b0, py, 14'b0});
    end
    if (cmd.march_adv) begin
      d    <= d + {7'b0, step_eff};
      posx <= posx + {{(POS_W-INC_W){inc_x[INC_W-1]}}, inc_x};
      posy <= posy + {{(POS_W-INC_W){inc_y[INC_W-1]}}, inc_y};
    end
    if (cmd.march_addr) begin
      outside <= out_now;
      addr_ok <= addr < 15'(MAP_CELLS);
    end
    if (cmd.march_test && outside) begin
      d <= {1'b0, maxd};
    end
    if (cmd.row_latch) begin
      if (d == '0) begin
        ceil_row <= -17'sd1;
      end else if (d_small) begin
        ceil_row <= $signed(-q_row);
      end else begin
        ceil_row <= $signed(q_row);
      end
    end
  end

  assign q_row = quo[CEIL_W-1:0];

  // row classification
  always_comb begin
    floor_row = CEIL_W'(SCREEN_HEIGHT) - ceil_row;
    ysig      = $signed({11'b0, row_cnt});
    if (ysig <= ceil_row) begin
      color = COL_CEIL;
    end else if (ysig <= floor_row) begin
      color = COL_WALL;
    end else begin
      color = COL_FLOOR;
    end
  end

  // row counter
  always_ff @(posedge clk) begin
    if (rst || cmd.load_item) begin
      row_cnt <= '0;
    end else if (cmd.emit_load) begin
      row_cnt <= row_cnt + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_data.out_column     <= column;
      out_data.row            <= row_cnt;
      out_data.pixel_color    <= color;
      out_data.wall_distance  <= d[DIST_W-1] ? 14'h3FFF : d[13:0];
      out_data.last_of_column <= row_cnt == 6'(SCREEN_HEIGHT - 1);
    end
  end

  // status
  always_comb begin
    st.clear_last = clr_addr == MAP_AW'(MAP_CELLS - 1);
    st.div_done   = div_done;
    st.march_go   = maxd != '0;
    st.march_done = outside || (addr_ok && map_q) || !(d < {1'b0, maxd});
    st.out_free   = !out_valid || out_ready;
    st.last_row   = row_cnt == 6'(SCREEN_HEIGHT - 1);
  end

endmodule

/* rtl/rcr_ctrl.sv */
// controller state machine sequencing clear, angle, trig, march, row bounds and emission
`timescale 1ns / 1ps
module rcr_ctrl import rcr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_action,
  input  dp_status_t st,
  output dp_cmd_t    cmd,
  output logic       in_ready
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == ACT_RENDER) begin
            cmd.load_item = 1'b1;
            state_next    = ST_ANG_START;
          end else begin
            cmd.map_write = 1'b1;
          end
        end
      end
      ST_ANG_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_ANG_WAIT;
      end
      ST_ANG_WAIT: begin
        if (st.div_done) begin
          cmd.ang_latch = 1'b1;
          state_next    = ST_SIN_X;
        end
      end
      ST_SIN_X: begin
        state_next = ST_SIN_Y;
      end
      ST_SIN_Y: begin
        cmd.trig_y = 1'b1;
        cmd.cap_sx = 1'b1;
        state_next = ST_TRIG_Y;
      end
      ST_TRIG_Y: begin
        cmd.march_init = 1'b1;
        state_next     = st.march_go ? ST_M_ADV : ST_ROW_START;
      end
      ST_M_ADV: begin
        cmd.march_adv = 1'b1;
        state_next    = ST_M_ADDR;
      end
      ST_M_ADDR: begin
        cmd.march_addr = 1'b1;
        state_next     = ST_M_TEST;
      end
      ST_M_TEST: begin
        cmd.march_test = 1'b1;
        state_next     = st.march_done ? ST_ROW_START : ST_M_ADV;
      end
      ST_ROW_START: begin
        cmd.div_start = 1'b1;
        cmd.div_row   = 1'b1;
        state_next    = ST_ROW_WAIT;
      end
      ST_ROW_WAIT: begin
        cmd.div_row = 1'b1;
        if (st.div_done) begin
          cmd.row_latch = 1'b1;
          state_next    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (st.out_free) begin
          cmd.emit_load = 1'b1;
          if (st.last_row) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* rtl/raycast_column_renderer.sv */
// top level: raycast column renderer, controller plus datapath
// after reset the wall map is cleared one cell a cycle, all 4096 cells, with no input transfer meanwhile
// a map write is taken straight from idle; a render runs the angle divide, the two sine reads,
// a march of up to max_distance/step_size steps (rounded up) through the wall map read port and
// the row bound divide, then emits one row per cycle while the consumer keeps up, 64 rows, with
// the output register decoupling the consumer; configuration registers return to their defaults on reset
`timescale 1ns / 1ps
module raycast_column_renderer import rcr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  dp_cmd_t    cmd;
  dp_status_t st;

  rcr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .st        (st),
    .cmd       (cmd),
    .in_ready  (in_ready)
  );

  rcr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* verif/rcr_checker.sv */
// checker: column renderer predictor with a scoreboard of expected pixels
`timescale 1ns / 1ps
module rcr_checker import rcr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_item_t         in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_item_t        out_data,
  output int               errors,
  output int               pending
);

  logic        wall_cells [MAP_CELLS];
  logic [10:0] fov;
  logic [13:0] max_dist;
  logic [7:0]  step_sz;
  logic [6:0]  map_w;
  logic [6:0]  map_h;
  logic [10:0] scr_w;
  out_item_t   pixel_q [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // sine of a phase in 1/4096 turn, signed Q1.14, taylor series in Q28
  function automatic int sine_q14(int unsigned p);
    int unsigned     quad;
    int unsigned     a;
    longint unsigned x, x2, t, s, r;
    quad = (p >> 10) & 3;
    a    = p & 1023;
    if (quad & 1) a = 1024 - a;
    x  = longint'(a) * 64'd411775;
    x2 = (x * x) >> 28;
    t  = 64'd268435456 - x2 / 72;
    t  = 64'd268435456 - ((x2 * t) >> 28) / 42;
    t  = 64'd268435456 - ((x2 * t) >> 28) / 20;
    t  = 64'd268435456 - ((x2 * t) >> 28) / 6;
    s  = (x * t) >> 28;
    r  = (s + 64'd8192) >> 14;
    if (r > 64'd16384) r = 64'd16384;
    return (quad & 2) ? -int'(r) : int'(r);
  endfunction

  // map cell holding a Q22 coordinate, -1 when off the map
  function automatic longint cell_of(longint pos, int unsigned lim);
    longint c;
    if (pos < 0) return -1;
    c = pos >>> 22;
    if (c >= longint'(lim)) return -1;
    return c;
  endfunction

  // march one ray and queue the 64 pixels of the column
  task automatic render_column(in_item_t it);
    int unsigned sw, stp, ray, q, d, addr;
    int          sx, sy;
    bit          hit;
    longint      posx, posy, cx, cy, ceil_r, floor_r;
    out_item_t   px;
    sw   = (scr_w == 0) ? 1 : scr_w;
    stp  = (step_sz == 0) ? 1 : step_sz;
    ray  = (it.player_angle + 4096 - (fov >> 1) + (it.column * fov) / sw) & 4095;
    q    = (((ray * TRIG_ENTRIES) >> 12) * 4096 / TRIG_ENTRIES) & 4095;
    sx   = sine_q14(q);
    sy   = sine_q14((q + 1024) & 4095);
    d    = 0;
    hit  = 0;
    while (!hit && d < max_dist) begin
      d += stp;
      posx = longint'(it.player_x) * 16384 + longint'(sx) * longint'(d);
      posy = longint'(it.player_y) * 16384 + longint'(sy) * longint'(d);
      cx = cell_of(posx, map_w);
      cy = cell_of(posy, map_h);
      if (cx < 0 || cy < 0) begin
        hit = 1;
        d   = max_dist;
      end else begin
        addr = int'(cy) * map_w + int'(cx);
        if (addr < MAP_CELLS && wall_cells[addr]) hit = 1;
      end
    end
    // ceiling and floor rows from the distance
    if (d == 0) begin
      ceil_r  = -1;
      floor_r = SCREEN_HEIGHT;
    end else begin
      ceil_r  = (longint'(SCREEN_HEIGHT) * (longint'(d) - 512)) / (2 * longint'(d));
      floor_r = SCREEN_HEIGHT - ceil_r;
    end
    for (int y = 0; y < SCREEN_HEIGHT; y++) begin
      px.out_column     = it.column;
      px.row            = y[5:0];
      px.pixel_color    = (y <= ceil_r) ? COL_CEIL : (y <= floor_r) ? COL_WALL : COL_FLOOR;
      px.wall_distance  = (d > 16383) ? 14'd16383 : d[13:0];
      px.last_of_column = (y == SCREEN_HEIGHT - 1);
      pixel_q.push_back(px);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      for (int i = 0; i < MAP_CELLS; i++) wall_cells[i] = 1'b0;
      fov      = 11'd683;
      max_dist = 14'd4096;
      step_sz  = 8'd26;
      map_w    = 7'd16;
      map_h    = 7'd16;
      scr_w    = 11'd120;
      pixel_q.delete();
    end else begin
      // output transfer against the oldest expected pixel
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel %h", $time, out_data);
        end else begin
          want = pixel_q.pop_front();
          if (out_data.out_column != want.out_column) begin
            errors++;
            $display("%0t: out_column exp %0d got %0d", $time, want.out_column,
                     out_data.out_column);
          end
          if (out_data.row != want.row) begin
            errors++;
            $display("%0t: row exp %0d got %0d", $time, want.row, out_data.row);
          end
          if (out_data.pixel_color != want.pixel_color) begin
            errors++;
            $display("%0t: pixel_color exp %h got %h", $time, want.pixel_color,
                     out_data.pixel_color);
          end
          if (out_data.wall_distance != want.wall_distance) begin
            errors++;
            $display("%0t: wall_distance exp %0d got %0d", $time, want.wall_distance,
                     out_data.wall_distance);
          end
          if (out_data.last_of_column != want.last_of_column) begin
            errors++;
            $display("%0t: last_of_column exp %0d got %0d", $time, want.last_of_column,
                     out_data.last_of_column);
          end
        end
      end
      // input transfer: map write or render
      if (in_valid && in_ready) begin
        if (in_data.action == ACT_WRITE) wall_cells[in_data.cell_index] = in_data.cell_is_wall;
        else render_column(in_data);
      end
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_FOV:          fov      = cfg_data[10:0];
          CFG_MAX_DISTANCE: max_dist = cfg_data[13:0];
          CFG_STEP_SIZE:    step_sz  = cfg_data[7:0];
          CFG_MAP_WIDTH:    map_w    = cfg_data[6:0];
          CFG_MAP_HEIGHT:   map_h    = cfg_data[6:0];
          CFG_SCREEN_WIDTH: scr_w    = cfg_data[10:0];
          default: ;
        endcase
      end
    end
    pending = pixel_q.size();
  end

endmodule

/* verif/raycast_column_renderer_test.sv */
// testbench top: stimulus, stalls, watchdog and verdict for the column renderer
`timescale 1ns / 1ps
module raycast_column_renderer_test;
  import rcr_pkg::*;

  localparam int IDLE_LIMIT = 250000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [2:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  int               errors;
  int               pending;
  int               idle_cycles = 0;
  int               cur_mw = 16;
  int               cur_mh = 16;
  int               cur_sw = 120;
  bit               send_no_gap = 0;
  bit               recv_no_gap = 0;

  always #5 clk = ~clk;

  raycast_column_renderer dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data
  );

  rcr_checker u_checker (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .errors, .pending
  );

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("raycast_column_renderer verification failed");
      $finish;
    end
  end

  // pixel receiver with random stalls and one long hold-off
  initial begin
    int gap;
    int taken;
    taken = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 99) == 0) recv_no_gap = ~recv_no_gap;
      gap = recv_no_gap ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      if (taken == 700) begin
        out_ready <= 1'b0;
        repeat (4000) @(posedge clk);
      end
    end
  end

  // offer one item and hold it until the transfer
  task automatic send_item(in_item_t it);
    int gap;
    if ($urandom_range(0, 39) == 0) send_no_gap = ~send_no_gap;
    gap = send_no_gap ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // drain all pixels, then allow a map write to finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_reg(logic [2:0] idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_W-1:0];
    @(posedge clk);
  endtask

  task automatic set_all(int fv, int md, int st, int mw, int mh, int sw);
    set_reg(CFG_FOV, fv);
    set_reg(CFG_MAX_DISTANCE, md);
    set_reg(CFG_STEP_SIZE, st);
    set_reg(CFG_MAP_WIDTH, mw);
    set_reg(CFG_MAP_HEIGHT, mh);
    set_reg(CFG_SCREEN_WIDTH, sw);
    cfg_we <= 1'b0;
    cur_mw = mw;
    cur_mh = mh;
    cur_sw = sw;
  endtask

  function automatic in_item_t rand_item();
    in_item_t it;
    it = in_item_t'({$urandom, $urandom});
    if ($urandom_range(0, 99) < 35) begin
      it.action = ACT_WRITE;
      if ($urandom_range(0, 9) != 0)
        it.cell_index = 12'($urandom_range(0, cur_mw * cur_mh - 1));
      it.cell_is_wall = ($urandom_range(0, 9) < 4);
    end else begin
      it.action = ACT_RENDER;
      if ($urandom_range(0, 9) != 0) begin
        it.column   = 10'($urandom_range(0, (cur_sw > 1024 ? 1024 : cur_sw) - 1));
        it.player_x = 14'($urandom_range(0, cur_mw * 256 - 1));
        it.player_y = 14'($urandom_range(0, cur_mh * 256 - 1));
      end
    end
    return it;
  endfunction

  function automatic in_item_t wr_cell(int idx, bit wall);
    in_item_t it;
    it = '0;
    it.action       = ACT_WRITE;
    it.cell_index   = idx[11:0];
    it.cell_is_wall = wall;
    return it;
  endfunction

  function automatic in_item_t rd_col(int col, int x, int y, int ang);
    in_item_t it;
    it = '0;
    it.action       = ACT_RENDER;
    it.column       = col[9:0];
    it.player_x     = x[13:0];
    it.player_y     = y[13:0];
    it.player_angle = ang[11:0];
    return it;
  endfunction

  task automatic rand_phase(int n);
    repeat (n) send_item(rand_item());
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    set_all(683, 4096, 26, 16, 16, 120);

    // directed: map extremes, headings, off-map and edge positions
    send_item(wr_cell(0, 1'b1));
    send_item(wr_cell(4095, 1'b1));
    send_item(wr_cell(5 * 16 + 8, 1'b1));
    send_item(wr_cell(8 * 16 + 12, 1'b1));
    send_item(rd_col(60, 8 * 256, 8 * 256, 0));
    send_item(rd_col(0, 8 * 256, 8 * 256, 1024));
    send_item(rd_col(119, 8 * 256, 8 * 256, 2048));
    send_item(rd_col(1023, 8 * 256, 8 * 256, 3072));
    send_item(rd_col(60, 8 * 256, 8 * 256, 4095));
    send_item(rd_col(60, 0, 0, 2048));
    send_item(rd_col(60, 16383, 16383, 0));
    send_item(rd_col(60, 16 * 256 - 1, 128, 1024));
    send_item(rd_col(30, 1 * 256 + 10, 1 * 256 + 10, 3584));
    send_item(wr_cell(5 * 16 + 8, 1'b0));
    send_item(rd_col(60, 8 * 256, 8 * 256, 0));
    send_item(wr_cell(0, 1'b0));
    wait_idle();
    // tiny distances: one step lands past the limit, and a wall in the start cell
    set_all(1, 1, 255, 1, 1, 1);
    send_item(rd_col(0, 128, 128, 0));
    send_item(rd_col(1023, 255, 0, 2047));
    send_item(wr_cell(0, 1'b1));
    send_item(rd_col(0, 128, 128, 1000));
    send_item(wr_cell(0, 1'b0));
    wait_idle();

    rand_phase(60);
    set_all(2047, 16383, 255, 64, 64, 1024);
    rand_phase(60);
    set_all(1, 1, 1, 1, 1, 1);
    rand_phase(40);
    set_all($urandom_range(1, 2047), $urandom_range(512, 8192), $urandom_range(16, 255),
            $urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 1024));
    rand_phase(60);
    set_all($urandom_range(1, 2047), $urandom_range(1, 16383), $urandom_range(32, 255),
            $urandom_range(1, 32), $urandom_range(1, 32), $urandom_range(1, 200));
    rand_phase(60);
    set_all(683, 4096, 26, 16, 16, 120);
    rand_phase(70);
    // finest step over the longest march
    set_all(1024, 16383, 1, 24, 24, 64);
    rand_phase(4);

    wait_idle();
    if (errors == 0) $display("raycast_column_renderer verification clean");
    else $display("raycast_column_renderer verification failed");
    $finish;
  end

endmodule
